### sv/feather_blend_pixel_defines.svh
// assertion macros shared by the feather blend modules
`ifndef FEATHER_BLEND_PIXEL_DEFINES_SVH
`define FEATHER_BLEND_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS
`define FBP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fbp assertion failed");
`define FBP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fbp assertion failed");
`else
`define FBP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FBP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

### sv/fbp_pkg.sv
`default_nettype none
package fbp_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int WEIGHT_W    = 17;
    localparam int PROD_W      = 34;
    localparam int WSUM_W      = 42;
    localparam int WTSUM_W     = 23;
    localparam int PIX_W       = 24;
    localparam int CENTER_W    = 28;
    localparam int DELTA_W     = 29;
    localparam int AXIS_W      = 32;
    localparam int MUL_W       = 61;
    localparam int PROJ_W      = 62;
    localparam int WSHIFT      = 18;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int DIV_STEPS   = 42;
    localparam int DIV_CNT_W   = 6;
    localparam int QUO_W       = 43;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PROJ_W-1:0] ONE_Q34 = PROJ_W'(64'h4_0000_0000);

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NULL_VALUE   = 2'd3;

    typedef struct packed {
        logic                       blend_enable;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] null_value;
    } cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]   prod;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_null;
        logic                       last;
    } entry_t;

    typedef enum logic [1:0] {
        BK_ACC,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

### sv/fbp_front.sv
`default_nettype none
module fbp_front (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [fbp_pkg::PIX_W-1:0]      pixel_x,
    input  wire logic signed [fbp_pkg::PIX_W-1:0]      pixel_y,
    input  wire logic signed [fbp_pkg::CENTER_W-1:0]   center_x,
    input  wire logic signed [fbp_pkg::CENTER_W-1:0]   center_y,
    input  wire logic signed [fbp_pkg::AXIS_W-1:0]     axis_one_x,
    input  wire logic signed [fbp_pkg::AXIS_W-1:0]     axis_one_y,
    input  wire logic signed [fbp_pkg::AXIS_W-1:0]     axis_two_x,
    input  wire logic signed [fbp_pkg::AXIS_W-1:0]     axis_two_y,
    input  wire logic signed [fbp_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic                                  is_null,
    input  wire logic                                  last_layer,
    input  wire logic [fbp_pkg::QCNT_W-1:0]            q_count,
    output logic                                       push,
    output fbp_pkg::entry_t                            push_entry
);

    localparam int OCC_W = fbp_pkg::QCNT_W + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [fbp_pkg::SAMPLE_W-1:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic n1_reg, n2_reg, n3_reg, n4_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg;

    logic signed [fbp_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [fbp_pkg::AXIS_W-1:0]  a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic signed [fbp_pkg::MUL_W-1:0]   m11_reg, m12_reg, m21_reg, m22_reg;
    logic signed [fbp_pkg::PROJ_W-1:0]  p1_reg, p2_reg;
    logic [fbp_pkg::WEIGHT_W-1:0]       w_reg;

    logic signed [fbp_pkg::DELTA_W-1:0] dx_next, dy_next;
    logic signed [fbp_pkg::MUL_W-1:0]   m11_next, m12_next, m21_next, m22_next;
    logic signed [fbp_pkg::PROJ_W-1:0]  p1_next, p2_next;
    logic [fbp_pkg::PROJ_W-1:0]         abs1, abs2, mag;
    logic [fbp_pkg::PROJ_W-1:0]         rest;
    logic [fbp_pkg::WEIGHT_W-1:0]       w_next;
    logic [OCC_W-1:0]                   occupancy;
    logic                               accept;

    assign occupancy = OCC_W'(q_count) + OCC_W'(v1_reg) + OCC_W'(v2_reg)
                     + OCC_W'(v3_reg) + OCC_W'(v4_reg);
    assign in_ready  = occupancy < OCC_W'(fbp_pkg::QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    always_comb begin
        dx_next  = fbp_pkg::DELTA_W'($signed({pixel_x, 4'b0000}))
                 - fbp_pkg::DELTA_W'(center_x);
        dy_next  = fbp_pkg::DELTA_W'($signed({pixel_y, 4'b0000}))
                 - fbp_pkg::DELTA_W'(center_y);
        m11_next = fbp_pkg::MUL_W'(dx_reg) * fbp_pkg::MUL_W'(a1x_reg);
        m12_next = fbp_pkg::MUL_W'(dy_reg) * fbp_pkg::MUL_W'(a1y_reg);
        m21_next = fbp_pkg::MUL_W'(dx_reg) * fbp_pkg::MUL_W'(a2x_reg);
        m22_next = fbp_pkg::MUL_W'(dy_reg) * fbp_pkg::MUL_W'(a2y_reg);
        p1_next  = fbp_pkg::PROJ_W'(m11_reg) + fbp_pkg::PROJ_W'(m12_reg);
        p2_next  = fbp_pkg::PROJ_W'(m21_reg) + fbp_pkg::PROJ_W'(m22_reg);
        abs1     = p1_reg[fbp_pkg::PROJ_W-1] ? fbp_pkg::PROJ_W'(-p1_reg) : p1_reg;
        abs2     = p2_reg[fbp_pkg::PROJ_W-1] ? fbp_pkg::PROJ_W'(-p2_reg) : p2_reg;
        mag      = (abs1 > abs2) ? abs1 : abs2;
        rest     = fbp_pkg::ONE_Q34 - mag;
        if (mag >= fbp_pkg::ONE_Q34) begin
            w_next = '0;
        end else begin
            w_next = rest[fbp_pkg::WSHIFT +: fbp_pkg::WEIGHT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        a1x_reg <= axis_one_x;
        a1y_reg <= axis_one_y;
        a2x_reg <= axis_two_x;
        a2y_reg <= axis_two_y;
        s1_reg  <= sample;
        n1_reg  <= is_null;
        l1_reg  <= last_layer;
        m11_reg <= m11_next;
        m12_reg <= m12_next;
        m21_reg <= m21_next;
        m22_reg <= m22_next;
        s2_reg  <= s1_reg;
        n2_reg  <= n1_reg;
        l2_reg  <= l1_reg;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        s3_reg  <= s2_reg;
        n3_reg  <= n2_reg;
        l3_reg  <= l2_reg;
        w_reg   <= w_next;
        s4_reg  <= s3_reg;
        n4_reg  <= n3_reg;
        l4_reg  <= l3_reg;
    end

    assign push              = v4_reg;
    assign push_entry.prod   = fbp_pkg::PROD_W'(s4_reg)
                             * fbp_pkg::PROD_W'($signed({1'b0, w_reg}));
    assign push_entry.weight = w_reg;
    assign push_entry.sample = s4_reg;
    assign push_entry.is_null = n4_reg;
    assign push_entry.last   = l4_reg;

endmodule
`default_nettype wire

### sv/fbp_queue.sv
`default_nettype none
`include "feather_blend_pixel_defines.svh"
module fbp_queue (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire fbp_pkg::entry_t             push_entry,
    input  wire logic                        pop,
    output fbp_pkg::entry_t                  head,
    output logic                             empty,
    output logic [fbp_pkg::QCNT_W-1:0]       count
);

    fbp_pkg::entry_t mem_reg [fbp_pkg::QUEUE_DEPTH];
    logic [fbp_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fbp_pkg::QCNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    `FBP_ASSERT_IMP(a_push_room, aclk, aresetn, push && !pop, count_reg < fbp_pkg::QCNT_W'(fbp_pkg::QUEUE_DEPTH))
    `FBP_ASSERT_IMP(a_pop_data, aclk, aresetn, pop, count_reg != '0)

endmodule
`default_nettype wire

### sv/fbp_back.sv
`default_nettype none
`include "feather_blend_pixel_defines.svh"
module fbp_back #(
    parameter int MAX_LAYERS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire fbp_pkg::cfg_t                      cfg,
    input  wire fbp_pkg::entry_t                    head,
    input  wire logic                               q_empty,
    output logic                                    pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [fbp_pkg::SAMPLE_W-1:0]     out_value,
    output logic                                    out_no_weight
);

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);

    fbp_pkg::back_state_t state_reg, state_next;

    logic signed [fbp_pkg::WSUM_W-1:0]   wsum_reg, wsum_next, wsum_acc;
    logic [fbp_pkg::WTSUM_W-1:0]         wtsum_reg, wtsum_next, wtsum_acc;
    logic signed [fbp_pkg::SAMPLE_W-1:0] first_reg, first_next, first_s;
    logic                                at_first_reg, at_first_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [fbp_pkg::WTSUM_W-1:0]         divisor_reg, divisor_next;
    logic [fbp_pkg::WTSUM_W-1:0]         rem_reg, rem_next;
    logic [fbp_pkg::WSUM_W-1:0]          quo_reg, quo_next;
    logic [fbp_pkg::DIV_CNT_W-1:0]       dcnt_reg, dcnt_next;
    logic                                neg_reg, neg_next;
    logic                                ovalid_reg, ovalid_next;
    logic signed [fbp_pkg::SAMPLE_W-1:0] oval_reg, oval_next;
    logic                                onw_reg, onw_next;

    logic                                out_free, take, add_it;
    logic [fbp_pkg::WTSUM_W:0]           rem_sh;
    logic                                qbit;
    logic signed [fbp_pkg::QUO_W-1:0]    qs;
    logic [fbp_pkg::WSUM_W-1:0]          wsum_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fbp_pkg::BK_ACC;
            wsum_reg     <= '0;
            wtsum_reg    <= '0;
            first_reg    <= '0;
            at_first_reg <= 1'b1;
            cnt_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wsum_reg     <= wsum_next;
            wtsum_reg    <= wtsum_next;
            first_reg    <= first_next;
            at_first_reg <= at_first_next;
            cnt_reg      <= cnt_next;
            ovalid_reg   <= ovalid_next;
        end
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        neg_reg     <= neg_next;
        oval_reg    <= oval_next;
        onw_reg     <= onw_next;
    end

    always_comb begin
        state_next    = state_reg;
        wsum_next     = wsum_reg;
        wtsum_next    = wtsum_reg;
        first_next    = first_reg;
        at_first_next = at_first_reg;
        cnt_next      = cnt_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        neg_next      = neg_reg;
        ovalid_next   = ovalid_reg;
        oval_next     = oval_reg;
        onw_next      = onw_reg;
        pop           = 1'b0;

        out_free  = !ovalid_reg || out_ready;
        first_s   = at_first_reg ? head.sample : first_reg;
        take      = cnt_reg < CNT_W'(MAX_LAYERS);
        add_it    = take && !head.is_null;
        wsum_acc  = wsum_reg + (add_it ? fbp_pkg::WSUM_W'(head.prod) : '0);
        wtsum_acc = wtsum_reg
                  + (add_it ? fbp_pkg::WTSUM_W'(head.weight) : '0);
        wsum_mag  = wsum_acc[fbp_pkg::WSUM_W-1] ? fbp_pkg::WSUM_W'(-wsum_acc)
                                                : fbp_pkg::WSUM_W'(wsum_acc);
        rem_sh    = {rem_reg, quo_reg[fbp_pkg::WSUM_W-1]};
        qbit      = rem_sh >= {1'b0, divisor_reg};
        qs        = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            fbp_pkg::BK_ACC: begin
                if (!q_empty && (!head.last || out_free)) begin
                    pop        = 1'b1;
                    first_next = first_s;
                    if (!head.last) begin
                        wsum_next     = wsum_acc;
                        wtsum_next    = wtsum_acc;
                        at_first_next = 1'b0;
                        if (take) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        wsum_next     = '0;
                        wtsum_next    = '0;
                        at_first_next = 1'b1;
                        cnt_next      = '0;
                        if (!cfg.blend_enable) begin
                            ovalid_next = 1'b1;
                            oval_next   = first_s;
                            onw_next    = 1'b0;
                        end else if (wtsum_acc == '0) begin
                            ovalid_next = 1'b1;
                            oval_next   = cfg.null_value;
                            onw_next    = 1'b1;
                        end else begin
                            divisor_next = wtsum_acc;
                            neg_next     = wsum_acc[fbp_pkg::WSUM_W-1];
                            quo_next     = wsum_mag;
                            rem_next     = '0;
                            dcnt_next    = '0;
                            state_next   = fbp_pkg::BK_DIV;
                        end
                    end
                end
            end
            fbp_pkg::BK_DIV: begin
                rem_next  = qbit ? fbp_pkg::WTSUM_W'(rem_sh - {1'b0, divisor_reg})
                                 : fbp_pkg::WTSUM_W'(rem_sh);
                quo_next  = {quo_reg[fbp_pkg::WSUM_W-2:0], qbit};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == fbp_pkg::DIV_CNT_W'(fbp_pkg::DIV_STEPS - 1)) begin
                    state_next = fbp_pkg::BK_OUT;
                end
            end
            fbp_pkg::BK_OUT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    onw_next    = 1'b0;
                    if (qs < fbp_pkg::QUO_W'(cfg.min_value)) begin
                        oval_next = cfg.min_value;
                    end else if (qs > fbp_pkg::QUO_W'(cfg.max_value)) begin
                        oval_next = cfg.max_value;
                    end else begin
                        oval_next = qs[fbp_pkg::SAMPLE_W-1:0];
                    end
                    state_next = fbp_pkg::BK_ACC;
                end
            end
            default: begin
                state_next = fbp_pkg::BK_ACC;
            end
        endcase
    end

    assign out_valid     = ovalid_reg;
    assign out_value     = oval_reg;
    assign out_no_weight = onw_reg;

    `FBP_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == fbp_pkg::BK_DIV, divisor_reg != '0)
    `FBP_ASSERT_NXT(a_null_flag, aclk, aresetn, pop && head.last && cfg.blend_enable && wtsum_acc == '0, ovalid_reg && onw_reg)

endmodule
`default_nettype wire

### sv/feather_blend_pixel.sv
`default_nettype none
// Feathered blend of one output pixel: each input beat is one layer's
// contribution, and the beat with tlast set ends the pixel and yields one
// result beat. A four-stage front pipeline computes the layer weight and
// sample*weight and accepts one beat per cycle while the eight-entry queue
// has room; the back end accumulates one queued beat per cycle except while
// it divides, clamps or holds a last beat for a free output. On the last
// beat of a pixel with blending enabled and a nonzero weight sum, a restoring
// divider runs, then a clamp state; null and pass-through results skip both.
module feather_blend_pixel #(
    parameter int MAX_LAYERS = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // pixel_x, pixel_y, center_x, center_y, axis_one_x, axis_one_y,
    // axis_two_x, axis_two_y, sample, zero fill
    input  wire logic [255:0]  s_tdata,
    // is_null
    input  wire logic          s_tuser,
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // pixel_value, zero fill
    output logic [23:0]        m_tdata,
    // no_weight
    output logic               m_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [fbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbp_pkg::SAMPLE_W-1:0]  cfg_data
);

    fbp_pkg::cfg_t   cfg_reg;
    fbp_pkg::entry_t push_entry, head;
    logic            push, pop, q_empty;
    logic [fbp_pkg::QCNT_W-1:0] q_count;
    logic signed [fbp_pkg::SAMPLE_W-1:0] out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_enable <= 1'b1;
            cfg_reg.min_value    <= '0;
            cfg_reg.max_value    <= 17'sh0FFFF;
            cfg_reg.null_value   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                fbp_pkg::REG_BLEND_ENABLE: cfg_reg.blend_enable <= cfg_data[0];
                fbp_pkg::REG_MIN_VALUE:    cfg_reg.min_value    <= $signed(cfg_data);
                fbp_pkg::REG_MAX_VALUE:    cfg_reg.max_value    <= $signed(cfg_data);
                fbp_pkg::REG_NULL_VALUE:   cfg_reg.null_value   <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    fbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .pixel_x    ($signed(s_tdata[23:0])),
        .pixel_y    ($signed(s_tdata[47:24])),
        .center_x   ($signed(s_tdata[75:48])),
        .center_y   ($signed(s_tdata[103:76])),
        .axis_one_x ($signed(s_tdata[135:104])),
        .axis_one_y ($signed(s_tdata[167:136])),
        .axis_two_x ($signed(s_tdata[199:168])),
        .axis_two_y ($signed(s_tdata[231:200])),
        .sample     ($signed(s_tdata[248:232])),
        .is_null    (s_tuser),
        .last_layer (s_tlast),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    fbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .count      (q_count)
    );

    fbp_back #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_value     (out_value),
        .out_no_weight (m_tuser)
    );

    assign m_tdata = {7'b0, out_value};

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [27:0] cx;
        logic signed [27:0] cy;
        logic signed [31:0] a1x;
        logic signed [31:0] a1y;
        logic signed [31:0] a2x;
        logic signed [31:0] a2y;
        logic signed [16:0] smp;
        bit                 nul;
        bit                 last;
    } layer_t;

    typedef struct {
        logic [16:0] value;
        bit          no_weight;
    } pixel_result_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [23:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [fbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fbp_pkg::SAMPLE_W-1:0]  cfg_data = '0;

    pixel_result_t pending_pixels[$];
    int  errors = 0;
    int  stuck_cycles = 0;
    bit  idling = 1;
    bit  hold_req = 0;

    // predictor state
    bit                 blend_on;
    logic signed [16:0] lo_bound, hi_bound, null_val;
    longint             sum_weighted, sum_weight;
    logic signed [16:0] first_smp;
    bit                 at_first;
    int                 layers_seen;

    feather_blend_pixel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint feather_weight(input layer_t l);
        longint dx, dy, p1, p2, m;
        dx = longint'(l.px) * 16 - longint'(l.cx);
        dy = longint'(l.py) * 16 - longint'(l.cy);
        p1 = dx * longint'(l.a1x) + dy * longint'(l.a1y);
        p2 = dx * longint'(l.a2x) + dy * longint'(l.a2y);
        if (p1 < 0) p1 = -p1;
        if (p2 < 0) p2 = -p2;
        m = (p1 > p2) ? p1 : p2;
        if (m >= (64'sd1 <<< 34)) return 0;
        return ((64'sd1 <<< 34) - m) >>> 18;
    endfunction

    task automatic accumulate_layer(input layer_t l);
        longint w, q;
        pixel_result_t r;
        if (at_first) begin
            first_smp = l.smp;
            at_first = 0;
        end
        if (layers_seen < 8) begin
            layers_seen++;
            if (!l.nul) begin
                w = feather_weight(l);
                sum_weighted += longint'(l.smp) * w;
                sum_weight += w;
            end
        end
        if (l.last) begin
            r.no_weight = 0;
            if (!blend_on) begin
                r.value = first_smp;
            end else if (sum_weight == 0) begin
                r.value = null_val;
                r.no_weight = 1;
            end else begin
                q = sum_weighted / sum_weight;
                if (q < longint'(lo_bound)) q = lo_bound;
                else if (q > longint'(hi_bound)) q = hi_bound;
                r.value = q[16:0];
            end
            pending_pixels.push_back(r);
            sum_weighted = 0;
            sum_weight = 0;
            at_first = 1;
            layers_seen = 0;
        end
    endtask

    // sender: called and returns at a falling edge
    task automatic send_layer(input layer_t l);
        int gap;
        gap = idling ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {7'b0, l.smp, l.a2y, l.a2x, l.a1y, l.a1x, l.cy, l.cx, l.py, l.px};
        s_tuser = l.nul;
        s_tlast = l.last;
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        accumulate_layer(l);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [fbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [16:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            fbp_pkg::REG_BLEND_ENABLE: blend_on = val[0];
            fbp_pkg::REG_MIN_VALUE:    lo_bound = val;
            fbp_pkg::REG_MAX_VALUE:    hi_bound = val;
            fbp_pkg::REG_NULL_VALUE:   null_val = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic drain;
        s_tvalid = 0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    function automatic layer_t rand_layer(input bit shaped);
        layer_t l;
        l.px = $urandom;
        l.py = $urandom;
        l.smp = $urandom;
        l.nul = ($urandom_range(0, 99) < 15);
        l.last = 0;
        if (shaped) begin
            l.cx = 28'(longint'(l.px) * 16 + $urandom_range(0, 512) - 256);
            l.cy = 28'(longint'(l.py) * 16 + $urandom_range(0, 512) - 256);
            l.a1x = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
            l.a1y = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
            l.a2x = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
            l.a2y = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
        end else begin
            l.cx = $urandom;
            l.cy = $urandom;
            l.a1x = $urandom;
            l.a1y = $urandom;
            l.a2x = $urandom;
            l.a2y = $urandom;
        end
        return l;
    endfunction

    task automatic send_pixel(input int n, input bit shaped);
        layer_t l;
        for (int i = 0; i < n; i++) begin
            l = rand_layer(shaped && $urandom_range(0, 9) != 0);
            l.last = (i == n - 1);
            send_layer(l);
        end
    endtask

    task automatic test_directed;
        layer_t l;
        l = rand_layer(1);
        // exact centre, full weight
        l.cx = 28'(longint'(l.px) * 16);
        l.cy = 28'(longint'(l.py) * 16);
        l.nul = 0;
        l.smp = 17'sd65535;
        l.last = 1;
        send_layer(l);
        l.smp = -17'sd65536;
        send_layer(l);
        // all fields at their extremes
        l = '{24'h7fffff, 24'h800000, 28'h7ffffff, 28'h8000000, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h7fffffff, 17'h0ffff, 0, 1};
        send_layer(l);
        l = '{24'h0, 24'h0, 28'h0, 28'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h10000, 0, 1};
        send_layer(l);
        l = '{24'hffffff, 24'hffffff, 28'hfffffff, 28'hfffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 17'h1ffff, 1, 1};
        send_layer(l);
        // only null layers: no weight
        l = rand_layer(1);
        l.nul = 1;
        send_layer(l);
        l.last = 1;
        send_layer(l);
        // more layers than the accumulator takes
        send_pixel(12, 1);
        send_pixel(9, 1);
        drain();
        // inverted bounds and extreme register values
        write_reg(fbp_pkg::REG_MIN_VALUE, 17'h0ffff);
        write_reg(fbp_pkg::REG_MAX_VALUE, 17'h10000);
        write_reg(fbp_pkg::REG_NULL_VALUE, 17'h10000);
        for (int i = 0; i < 4; i++) send_pixel($urandom_range(1, 4), 1);
        l = rand_layer(1);
        l.nul = 1;
        l.last = 1;
        send_layer(l);
        drain();
        // pass-through, first layer null
        write_reg(fbp_pkg::REG_BLEND_ENABLE, 1'b0);
        write_reg(fbp_pkg::REG_NULL_VALUE, 17'h0ffff);
        l = rand_layer(1);
        l.nul = 1;
        send_layer(l);
        send_pixel(3, 1);
        drain();
        write_reg(fbp_pkg::REG_BLEND_ENABLE, 1'b1);
        write_reg(fbp_pkg::REG_MIN_VALUE, 17'h10000);
        write_reg(fbp_pkg::REG_MAX_VALUE, 17'h0ffff);
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 5; phase++) begin
            idling = (phase != 2);
            for (int p = 0; p < 80; p++) send_pixel($urandom_range(1, 10), 1);
            drain();
            write_reg(fbp_pkg::REG_BLEND_ENABLE, ($urandom_range(0, 3) != 0));
            write_reg(fbp_pkg::REG_MIN_VALUE,
                      17'($signed($urandom_range(0, 98303)) - 32768));
            write_reg(fbp_pkg::REG_MAX_VALUE,
                      17'($signed($urandom_range(0, 98303)) - 32768));
            write_reg(fbp_pkg::REG_NULL_VALUE, $urandom);
        end
        idling = 1;
    endtask

    task automatic test_backpressure;
        hold_req = 1;
        for (int p = 0; p < 30; p++) send_pixel($urandom_range(1, 3), 1);
        drain();
        for (int p = 0; p < 10; p++) begin
            send_pixel($urandom_range(1, 8), 1);
            drain();
        end
    endtask

    // receiver
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 0;
                repeat (300) @(negedge aclk);
                hold_req = 0;
            end
            gap = idling ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_tready = 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            if (pending_pixels.size() == 0) begin
                $display("%0t unexpected pixel: actual value %h no_weight %b",
                         $time, m_tdata[16:0], m_tuser);
                errors++;
            end else begin
                pixel_result_t e;
                e = pending_pixels.pop_front();
                if (m_tdata[16:0] !== e.value) begin
                    $display("%0t pixel_value mismatch: expected %h actual %h",
                             $time, e.value, m_tdata[16:0]);
                    errors++;
                end
                if (m_tuser !== e.no_weight) begin
                    $display("%0t no_weight mismatch: expected %b actual %b",
                             $time, e.no_weight, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 5000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        blend_on = 1;
        lo_bound = 0;
        hi_bound = 17'h0ffff;
        null_val = 0;
        sum_weighted = 0;
        sum_weight = 0;
        first_smp = 0;
        at_first = 1;
        layers_seen = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### feather_blend_pixel.f
+incdir+sv
sv/fbp_pkg.sv
sv/fbp_front.sv
sv/fbp_queue.sv
sv/fbp_back.sv
sv/feather_blend_pixel.sv
bench/testbench.sv
